/* rtl/htbd_pkg.sv */
`default_nettype none

package htbd_pkg;

  localparam logic       MODE_LOAD   = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    RA_CUR,
    RA_NODE,
    RA_CHILD
  } rd_sel_t;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       l_take;
    logic       l_fin;
    logic       d_take;
    logic       d_adv;
    logic       cur_root;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_sym;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic l_child_zero;
    logic d_child_zero;
    logic table_full;
    logic last_bit;
    logic leaf;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/htbd_ctrl.sv */
`default_nettype none

module htbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_stall,
  input  wire htbd_pkg::stat_t stat,
  output htbd_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LSTEP,
    S_LFIN,
    S_LREAD,
    S_DSTEP,
    S_DLEAF
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = htbd_pkg::RA_CUR;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = htbd_pkg::RA_CUR;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_mode == htbd_pkg::MODE_DECODE) begin
            state_nxt = S_DSTEP;
          end else if (!stat.len_zero) begin
            state_nxt = S_LSTEP;
          end
        end
      end
      S_LSTEP: begin
        if (stat.l_child_zero && stat.table_full) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = htbd_pkg::ST_FULL;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.l_take = 1'b1;
          state_nxt  = S_LFIN;
        end
      end
      S_LFIN: begin
        cmd.l_fin = 1'b1;
        state_nxt = stat.last_bit ? S_IDLE : S_LREAD;
      end
      S_LREAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = htbd_pkg::RA_NODE;
        state_nxt  = S_LSTEP;
      end
      S_DSTEP: begin
        if (stat.d_child_zero) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = htbd_pkg::ST_MISSING;
            cmd.cur_root    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.d_take = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = htbd_pkg::RA_CHILD;
          state_nxt  = S_DLEAF;
        end
      end
      S_DLEAF: begin
        if (stat.leaf) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = htbd_pkg::ST_OK;
            cmd.emit_sym    = 1'b1;
            cmd.cur_root    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.d_adv = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/htbd_dp.sv */
`default_nettype none

module htbd_dp #(
  parameter int MAX_NODES    = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      in_symbol,
  input  wire logic [31:0]     in_code_bits,
  input  wire logic [5:0]      in_code_length,
  input  wire logic            in_bit_req,
  input  wire htbd_pkg::cmd_t  cmd,
  output htbd_pkg::stat_t      stat,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_symbol_out,
  output logic [1:0]           out_status
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NFW = NW + 1;
  localparam int PW  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam logic [6:0]     MAXL  = 7'(MAX_CODE_LEN);
  localparam logic [NFW-1:0] NFULL = NFW'(MAX_NODES);

  logic [2*NW-1:0] word_mem [MAX_NODES];
  logic [7:0]      sym_mem  [MAX_NODES];

  logic [2*NW-1:0] root_r;
  logic [2*NW-1:0] rd_word_r;
  logic [7:0]      rd_sym_r;
  logic [NW-1:0]   cur_r;
  logic [NW-1:0]   node_r;
  logic [NW-1:0]   child_r;
  logic [NFW-1:0]  next_free_r;
  logic [PW-1:0]   pos_r;
  logic [31:0]     code_r;
  logic [7:0]      sym_r;
  logic            bit_r;
  logic            need_clr_r;
  logic            out_valid_r;
  logic [7:0]      out_sym_r;
  logic [1:0]      out_status_r;

  logic [6:0]      len_ext;
  logic [6:0]      len_sat;
  logic [31:0]     code_sh;
  logic            code_bit;
  logic [2*NW-1:0] lw;
  logic [2*NW-1:0] dw;
  logic [NW-1:0]   lchild;
  logic [NW-1:0]   dchild;
  logic [NW-1:0]   alloc_idx;
  logic [NW-1:0]   rd_addr;
  logic [2*NW-1:0] link_word;
  logic            link_new;
  logic            wr_en;
  logic [NW-1:0]   wr_addr;
  logic [2*NW-1:0] wr_data;
  logic            sym_we;
  logic            out_free;

  assign len_ext   = {1'b0, in_code_length};
  assign len_sat   = (len_ext > MAXL) ? MAXL : len_ext;
  assign code_sh   = code_r >> pos_r;
  assign code_bit  = code_sh[0];
  assign lw        = (node_r == '0) ? root_r : rd_word_r;
  assign dw        = (cur_r == '0) ? root_r : rd_word_r;
  assign lchild    = code_bit ? lw[2*NW-1:NW] : lw[NW-1:0];
  assign dchild    = bit_r ? dw[2*NW-1:NW] : dw[NW-1:0];
  assign alloc_idx = next_free_r[NW-1:0];
  assign link_new  = cmd.l_take && (lchild == '0);
  assign link_word = code_bit ? {alloc_idx, lw[NW-1:0]} : {lw[2*NW-1:NW], alloc_idx};
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    unique case (cmd.rd_sel)
      htbd_pkg::RA_CUR:   rd_addr = cur_r;
      htbd_pkg::RA_NODE:  rd_addr = node_r;
      htbd_pkg::RA_CHILD: rd_addr = dchild;
      default:            rd_addr = cur_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = link_word;
    if (link_new && (node_r != '0)) begin
      wr_en = 1'b1;
    end else if (cmd.l_fin && need_clr_r) begin
      wr_en   = 1'b1;
      wr_addr = child_r;
      wr_data = '0;
    end
  end

  assign sym_we = cmd.l_fin && (pos_r == '0);

  always_comb begin
    stat              = '0;
    stat.len_zero     = (in_code_length == 6'd0);
    stat.l_child_zero = (lchild == '0);
    stat.d_child_zero = (dchild == '0);
    stat.table_full   = (next_free_r == NFULL);
    stat.last_bit     = (pos_r == '0);
    stat.leaf         = (rd_word_r == '0);
    stat.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_data;
    end
    if (sym_we) begin
      sym_mem[child_r] <= sym_r;
    end
    if (cmd.rd_en) begin
      rd_word_r <= word_mem[rd_addr];
      rd_sym_r  <= sym_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_r  <= in_symbol;
      code_r <= in_code_bits;
      pos_r  <= PW'(len_sat - 7'd1);
      bit_r  <= in_bit_req;
      node_r <= '0;
    end
    if (cmd.l_take) begin
      child_r    <= (lchild == '0) ? alloc_idx : lchild;
      need_clr_r <= (lchild == '0) || (pos_r == '0);
    end
    if (cmd.l_fin) begin
      node_r <= child_r;
      pos_r  <= pos_r - PW'(1);
    end
    if (cmd.d_take) begin
      child_r <= dchild;
    end
    if (cmd.emit) begin
      out_sym_r    <= cmd.emit_sym ? rd_sym_r : 8'd0;
      out_status_r <= cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      cur_r       <= '0;
      next_free_r <= NFW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (link_new) begin
        next_free_r <= next_free_r + NFW'(1);
        if (node_r == '0) begin
          root_r <= link_word;
        end
      end
      if (cmd.cur_root) begin
        cur_r <= '0;
      end else if (cmd.d_adv) begin
        cur_r <= child_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

/* rtl/huffman_tree_build_and_decode.sv */
`default_nettype none

// Code tree builder and bit-serial decoder. A load item (mode 0) walks the
// tree from the root along its prefix code, MSB first, allocating missing
// nodes and setting the symbol of the last one; it returns nothing unless the
// node table runs out (status 2). A decode item (mode 1) moves one step on its
// bit and returns the symbol (status 0) on reaching a leaf, or status 1 on a
// missing branch. Node links but the root's live in one single-port memory
// with a registered read, so a decode item does accept, step and, if it
// lands on a node, leaf check, and a load does link, finish and next-node
// read per code bit, bar the last. No clearing pass follows reset: only
// allocated nodes are ever read, and each is zeroed on allocation. An
// output register lets the next item be taken while a result is pending.

module huffman_tree_build_and_decode #(
  parameter int MAX_NODES    = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_symbol,
  input  wire logic [31:0] in_code_bits,
  input  wire logic [5:0]  in_code_length,
  input  wire logic        in_bit_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_symbol_out,
  output logic [1:0]       out_status
);

  htbd_pkg::cmd_t  cmd;
  htbd_pkg::stat_t stat;

  htbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  htbd_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .in_bit_req     (in_bit_req),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_out (out_symbol_out),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

/* rtl/htbd_checker.sv */
`default_nettype none

module htbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_mode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_symbol_out,
  input wire logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_out) && $stable(out_status))
    else $error("stalled result changed");

  a_err_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != htbd_pkg::ST_OK) |-> out_symbol_out == 8'd0)
    else $error("error result carries a symbol");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == htbd_pkg::ST_OK) || (out_status == htbd_pkg::ST_MISSING)
                  || (out_status == htbd_pkg::ST_FULL))
    else $error("unknown status code");

  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == htbd_pkg::MODE_DECODE) |=> in_stall)
    else $error("decode item did not occupy the block");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind huffman_tree_build_and_decode htbd_checker u_htbd_checker (.*);

`default_nettype wire

/* tb/tb_huffman_tree_build_and_decode.sv */
`default_nettype none

module tb_huffman_tree_build_and_decode;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = 512;
  localparam int MAX_LEN     = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [7:0] sym;
    logic [1:0] status;
  } outcome_t;

  class code_tree_board;
    logic [8:0]  left_link [NODES];
    logic [8:0]  right_link [NODES];
    logic [7:0]  leaf_sym [NODES];
    bit          sym_written [NODES];
    logic [31:0] route_code [NODES];
    int          route_len [NODES];
    int          cur_node;
    int          free_node;
    outcome_t    symbols_due[$];
    int          errors;

    function new();
      for (int n = 0; n < NODES; n++) begin
        left_link[n]   = '0;
        right_link[n]  = '0;
        leaf_sym[n]    = '0;
        sym_written[n] = 1'b0;
        route_code[n]  = '0;
        route_len[n]   = 0;
      end
      cur_node  = 0;
      free_node = 1;
      errors    = 0;
    endfunction

    function int child_of(int n, logic b);
      return b ? int'(right_link[n]) : int'(left_link[n]);
    endfunction

    function bit table_full();
      return free_node >= NODES;
    endfunction

    function int pending();
      return symbols_due.size();
    endfunction

    function void queue_outcome(logic [7:0] sym, logic [1:0] status);
      outcome_t o;
      o.sym    = sym;
      o.status = status;
      symbols_due.insert(symbols_due.size(), o);
    endfunction

    function void walk_code(logic [7:0] sym, logic [31:0] code, logic [5:0] length);
      int   n;
      int   depth;
      int   c;
      logic b;
      n = 0;
      depth = int'(length);
      if (depth == 0) return;
      if (depth > MAX_LEN) depth = MAX_LEN;
      for (int p = depth - 1; p >= 0; p--) begin
        b = code[p];
        c = child_of(n, b);
        if (c == 0) begin
          if (free_node >= NODES) begin
            queue_outcome(8'd0, htbd_pkg::ST_FULL);
            return;
          end
          c = free_node;
          free_node++;
          left_link[c]   = '0;
          right_link[c]  = '0;
          sym_written[c] = 1'b0;
          route_code[c]  = code >> p;
          route_len[c]   = depth - p;
          if (b) right_link[n] = 9'(c);
          else left_link[n] = 9'(c);
        end
        if (p == 0) begin
          leaf_sym[c]    = sym;
          sym_written[c] = 1'b1;
          left_link[c]   = '0;
          right_link[c]  = '0;
        end
        n = c;
      end
    endfunction

    function void step_bit(logic b);
      int c;
      c = child_of(cur_node, b);
      if (c == 0) begin
        cur_node = 0;
        queue_outcome(8'd0, htbd_pkg::ST_MISSING);
      end else if (left_link[c] == '0 && right_link[c] == '0) begin
        cur_node = 0;
        queue_outcome(leaf_sym[c], htbd_pkg::ST_OK);
      end else begin
        cur_node = c;
      end
    endfunction

    function void note_item(logic m, logic [7:0] s, logic [31:0] cb, logic [5:0] cl,
                            logic br);
      if (m == htbd_pkg::MODE_LOAD) walk_code(s, cb, cl);
      else step_bit(br);
    endfunction

    // a childless node that never got a symbol must not be reached
    function bit lands_on_blank(logic b);
      int c;
      c = child_of(cur_node, b);
      return c != 0 && left_link[c] == '0 && right_link[c] == '0 && !sym_written[c];
    endfunction

    function logic pick_bit();
      bit has_l;
      bit has_r;
      has_l = left_link[cur_node] != '0;
      has_r = right_link[cur_node] != '0;
      if ($urandom_range(99) < 12 || has_l == has_r) return 1'($urandom_range(1));
      return has_r;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] sym, logic [1:0] status);
      outcome_t want;
      if (symbols_due.size() == 0) begin
        report($sformatf("result with nothing pending: symbol %0h status %0d", sym, status));
        return;
      end
      want = symbols_due.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (sym !== want.sym)
        report($sformatf("symbol %0h, want %0h", sym, want.sym));
    endtask
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_mode        = htbd_pkg::MODE_LOAD;
  logic [7:0]  in_symbol      = '0;
  logic [31:0] in_code_bits   = '0;
  logic [5:0]  in_code_length = '0;
  logic        in_bit_req     = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_symbol_out;
  logic [1:0]  out_status;

  bit             calm        = 1'b0;
  bit             hold_req    = 1'b0;
  int             quiet_cycles = 0;
  code_tree_board tree        = new();

  huffman_tree_build_and_decode #(
    .MAX_NODES   (NODES),
    .MAX_CODE_LEN(MAX_LEN)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_symbol     (in_symbol),
    .in_code_bits  (in_code_bits),
    .in_code_length(in_code_length),
    .in_bit_req    (in_bit_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_symbol_out(out_symbol_out),
    .out_status    (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task send_item(logic m, logic [7:0] s, logic [31:0] cb, logic [5:0] cl, logic br);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_symbol      <= s;
    in_code_bits   <= cb;
    in_code_length <= cl;
    in_bit_req     <= br;
    do @(posedge clk); while (in_stall);
    tree.note_item(m, s, cb, cl, br);
  endtask

  task send_decode();
    logic b;
    int   c;
    b = tree.pick_bit();
    if (tree.lands_on_blank(b)) begin
      c = tree.child_of(tree.cur_node, b);
      send_item(htbd_pkg::MODE_LOAD, 8'($urandom_range(255)), tree.route_code[c],
                6'(tree.route_len[c]), 1'($urandom_range(1)));
      if (tree.lands_on_blank(b)) return;
    end
    send_item(htbd_pkg::MODE_DECODE, 8'($urandom_range(255)), $urandom,
              6'($urandom_range(63)), b);
  endtask

  task random_step();
    int r;
    r = $urandom_range(99);
    if (r < 14)
      send_item(htbd_pkg::MODE_LOAD, 8'($urandom_range(255)), $urandom,
                6'($urandom_range(1, 8)), 1'($urandom_range(1)));
    else if (r < 17)
      send_item(htbd_pkg::MODE_LOAD, 8'($urandom_range(255)), $urandom,
                6'($urandom_range(63)), 1'($urandom_range(1)));
    else
      send_decode();
  endtask

  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tree.pending() != 0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tree.check_result(out_symbol_out, out_status);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_item(htbd_pkg::MODE_LOAD, 8'h77, 32'hFFFF_FFFF, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_LOAD, 8'hAB, 32'h0, 6'd1, 1'b0);
    send_item(htbd_pkg::MODE_LOAD, 8'h55, 32'h2, 6'd2, 1'b0);
    send_item(htbd_pkg::MODE_LOAD, 8'hFF, 32'h3, 6'd2, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
    send_item(htbd_pkg::MODE_LOAD, 8'h12, 32'h1, 6'd1, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_LOAD, 8'h3C, 32'h0, 6'd32, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
    send_item(htbd_pkg::MODE_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    send_item(htbd_pkg::MODE_LOAD, 8'hC3, 32'h8000_0000, 6'd32, 1'b0);
    drain();

    repeat (300) random_step();

    calm = 1'b1;
    repeat (150) random_step();
    calm = 1'b0;

    hold_req = 1'b1;
    repeat (60) send_decode();
    drain();

    while (!tree.table_full())
      send_item(htbd_pkg::MODE_LOAD, 8'($urandom_range(255)), $urandom, 6'd32,
                1'($urandom_range(1)));
    send_item(htbd_pkg::MODE_LOAD, 8'($urandom_range(255)), $urandom, 6'd32,
              1'($urandom_range(1)));

    repeat (400) random_step();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tree.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
